@@ sv/npc_pkg.sv @@
package npc_pkg;

   localparam int unsigned MAX_LEN = 1024;
   localparam int unsigned ADDR_W  = $clog2(MAX_LEN);
   localparam int unsigned CNT_W   = ADDR_W + 1;
   localparam int unsigned COEFF_W = 30;
   localparam int unsigned LG_MAX  = ADDR_W;
   localparam int unsigned TW_DEPTH = MAX_LEN / 2;
   localparam int unsigned TW_W     = ADDR_W - 1;

   localparam longint unsigned MODULUS = 998244353;
   localparam longint unsigned ROOT    = 3;

   localparam logic [COEFF_W-1:0] MOD_C = COEFF_W'(MODULUS);
   localparam logic [31:0] MOD1_32 = 32'(MODULUS);
   localparam logic [31:0] MOD2_32 = 32'(2 * MODULUS);

   // Barrett constant floor(2^60 / MODULUS), 31 bits
   localparam logic [30:0] MU_C = 31'((64'd1 << 60) / MODULUS);

   typedef enum logic [1:0] {
      OP_LOAD_A  = 2'd0,
      OP_LOAD_B  = 2'd1,
      OP_COMPUTE = 2'd2,
      OP_READ    = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_LONG  = 2'd2,
      ST_RANGE = 2'd3
   } status_type;

   typedef logic [COEFF_W-1:0] tw_table_type [TW_DEPTH];
   typedef logic [COEFF_W-1:0] scale_table_type [LG_MAX+1];

   function automatic logic [COEFF_W-1:0] pow_mod(input longint unsigned base,
                                                  input longint unsigned e);
      longint unsigned r;
      longint unsigned b;
      longint unsigned x;
      r = 1;
      b = base % MODULUS;
      x = e;
      for (int k = 0; k < 64; k++) begin
         if (x[0]) r = (r * b) % MODULUS;
         b = (b * b) % MODULUS;
         x = x >> 1;
      end
      return COEFF_W'(r);
   endfunction

   function automatic tw_table_type make_twiddles(input logic inverse);
      tw_table_type t;
      longint unsigned w;
      longint unsigned z;
      w = longint'(pow_mod(ROOT, (MODULUS - 1) / MAX_LEN));
      if (inverse) w = longint'(pow_mod(w, MAX_LEN - 1));
      z = 1;
      for (int k = 0; k < TW_DEPTH; k++) begin
         t[k] = COEFF_W'(z);
         z = (z * w) % MODULUS;
      end
      return t;
   endfunction

   function automatic scale_table_type make_scales();
      scale_table_type t;
      for (int k = 0; k <= LG_MAX; k++) begin
         t[k] = pow_mod(64'd1 << k, MODULUS - 2);
      end
      return t;
   endfunction

   function automatic logic [COEFF_W-1:0] mod_add(input logic [COEFF_W-1:0] p,
                                                  input logic [COEFF_W-1:0] q);
      logic [COEFF_W:0] s;
      s = {1'b0, p} + {1'b0, q};
      if (s >= {1'b0, MOD_C}) s = s - {1'b0, MOD_C};
      return s[COEFF_W-1:0];
   endfunction

   function automatic logic [COEFF_W-1:0] mod_sub(input logic [COEFF_W-1:0] p,
                                                  input logic [COEFF_W-1:0] q);
      logic [COEFF_W:0] s;
      if (p >= q) s = {1'b0, p} - {1'b0, q};
      else s = {1'b0, p} + {1'b0, MOD_C} - {1'b0, q};
      return s[COEFF_W-1:0];
   endfunction

endpackage

@@ sv/ntt_polynomial_convolution.sv @@
// Channel  Direction  tdata (low bit up)               tuser
// req      in         coeff_in[29:0], read_index[39:30] op[1:0]
// rsp      out        coeff_out[29:0], product_len[40:30] status[1:0]
//
// A load is written at its transfer and the block stays ready; a read passes through S_READ
// into S_OUT, where it waits for the output register. A compute walks the memories over
// 3 * lg * sz/2 butterflies and 2 * sz entries, one at a time on the one shared modular
// multiplier; a failed compute, or a repeated one with no load between, answers through S_OUT.
// Reset is synchronous and clears counts, flags and handshake state, not memory contents.
// A stalled result holds in the output register while loads keep being accepted.
module ntt_polynomial_convolution (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // coeff_in[29:0], read_index[39:30]
   input  logic [1:0]  req_tuser,   // op[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // coeff_out[29:0], product_len[40:30], zero fill
   output logic [1:0]  rsp_tuser    // status[1:0]
);

   localparam int unsigned AW = npc_pkg::ADDR_W;
   localparam int unsigned CW = npc_pkg::CNT_W;
   localparam int unsigned DW = npc_pkg::COEFF_W;
   localparam int unsigned TWW = npc_pkg::TW_W;

   localparam npc_pkg::tw_table_type TW_FWD = npc_pkg::make_twiddles(1'b0);
   localparam npc_pkg::tw_table_type TW_INV = npc_pkg::make_twiddles(1'b1);
   localparam npc_pkg::scale_table_type SCALES = npc_pkg::make_scales();

   typedef enum logic [3:0] {
      S_IDLE, S_READ, S_OUT,
      S_BF_RD, S_BF_OP, S_BF_MUL, S_BF_WR0, S_BF_WR1,
      S_PW_RD, S_PW_OP, S_PW_MUL, S_PW_WR
   } state_type;

   typedef enum logic [2:0] {
      PH_FWD_A, PH_FWD_B, PH_PROD, PH_INV, PH_SCALE
   } phase_type;

   state_type state_ff;
   phase_type phase_ff;

   // coefficient memories: a holds the product after compute
   logic [DW-1:0] mem_a [npc_pkg::MAX_LEN];
   logic [DW-1:0] mem_b [npc_pkg::MAX_LEN];
   logic [DW-1:0] a_q0_ff, a_q1_ff, b_q0_ff, b_q1_ff, tw_q_ff;

   logic          a_we, b_we;
   logic [AW-1:0] a_waddr, b_waddr, raddr0, raddr1;
   logic [DW-1:0] a_wdata, b_wdata;

   logic [CW-1:0] count_a_ff, count_b_ff, result_len_ff;
   logic          overflow_ff, ready_ff, restart_ff;
   logic [3:0]    lg_ff, hlg_ff;
   logic [TWW-1:0] bfly_ff;
   logic [AW-1:0] idx_ff;

   logic [DW-1:0] hold_u_ff, hold_sum_ff, wd0_ff, wd1_ff;

   // multiplier pipeline
   logic [DW-1:0] op_a_ff, op_b_ff;
   logic          mstart_ff, mv1_ff, mv2_ff, mv3_ff, mv4_ff;
   logic [59:0]   x1_ff;
   logic [31:0]   x2_ff;
   logic [30:0]   q_ff;
   logic [31:0]   r_ff;
   logic [DW-1:0] prod_ff;
   logic [61:0]   qprod;
   logic [60:0]   qmod;
   logic [31:0]   rdiff;

   // pending result and output register
   logic [DW-1:0] res_coeff_ff, rsp_coeff_ff;
   logic [1:0]    res_status_ff, rsp_status_ff;
   logic [CW-1:0] res_len_ff, rsp_len_ff;
   logic          rsp_valid_ff;
   logic          rsp_load;

   // request fields
   npc_pkg::op_type req_op;
   logic [DW-1:0] req_coeff, coeff_red;
   logic [AW-1:0] req_index;
   logic          req_fire;

   // addressing
   logic [CW-1:0] sz, half, plen, cur_count;
   logic [3:0]    plen_lg;
   logic [AW-1:0] mask, bfly_w, addr_u, addr_v;
   logic [TWW-1:0] tw_idx;
   logic          bfly_last, idx_last, fwd, use_b, first_fwd;
   logic [DW-1:0] u_val, v_val;

   assign req_op    = npc_pkg::op_type'(req_tuser);
   assign req_coeff = req_tdata[DW-1:0];
   assign req_index = req_tdata[39:30];
   assign req_fire  = req_tvalid && req_tready;
   assign req_tready = (state_ff == S_IDLE);

   assign coeff_red = (req_coeff >= npc_pkg::MOD_C) ? req_coeff - npc_pkg::MOD_C : req_coeff;

   assign plen = count_a_ff + count_b_ff - CW'(1);

   // load the output register once it is free
   assign rsp_load = (state_ff == S_OUT) && (!rsp_valid_ff || rsp_tready);

   // least lg with 2^lg not below plen
   always_comb begin
      plen_lg = '0;
      for (int k = 0; k < npc_pkg::LG_MAX + 1; k++) begin
         if ((CW'(1) << k) < plen) plen_lg = plen_lg + 4'd1;
      end
   end

   assign sz   = CW'(1) << lg_ff;
   assign half = sz >> 1;
   assign mask = (AW'(1) << hlg_ff) - AW'(1);
   assign bfly_w = AW'(bfly_ff);
   // insert a zero bit at position hlg to find the upper half partner
   assign addr_u = ((bfly_w & ~mask) << 1) | (bfly_w & mask);
   assign addr_v = addr_u | (AW'(1) << hlg_ff);
   assign tw_idx = TWW'((bfly_w & mask) << (4'(TWW) - hlg_ff));
   assign bfly_last = ({1'b0, bfly_w} == half - CW'(1));
   assign idx_last  = ({1'b0, idx_ff} == sz - CW'(1));

   assign fwd   = (phase_ff == PH_FWD_A) || (phase_ff == PH_FWD_B);
   assign use_b = (phase_ff == PH_FWD_B);
   assign first_fwd = fwd && (hlg_ff == lg_ff - 4'd1);
   assign cur_count = use_b ? count_b_ff : count_a_ff;

   // entries beyond the operand count are the zero padding
   always_comb begin
      u_val = use_b ? b_q0_ff : a_q0_ff;
      v_val = use_b ? b_q1_ff : a_q1_ff;
      if (first_fwd && ({1'b0, addr_u} >= cur_count)) u_val = '0;
      if (first_fwd && ({1'b0, addr_v} >= cur_count)) v_val = '0;
   end

   // memory port steering
   always_comb begin
      a_we = 1'b0;
      b_we = 1'b0;
      a_waddr = addr_u;
      b_waddr = addr_u;
      a_wdata = wd0_ff;
      b_wdata = wd0_ff;
      raddr0 = addr_u;
      raddr1 = addr_v;
      unique case (state_ff)
         S_IDLE: begin
            raddr0 = req_index;
            a_waddr = restart_ff ? '0 : count_a_ff[AW-1:0];
            b_waddr = restart_ff ? '0 : count_b_ff[AW-1:0];
            a_wdata = coeff_red;
            b_wdata = coeff_red;
            if (req_fire && (req_op == npc_pkg::OP_LOAD_A)) begin
               a_we = restart_ff || (count_a_ff < CW'(npc_pkg::MAX_LEN));
            end
            if (req_fire && (req_op == npc_pkg::OP_LOAD_B)) begin
               b_we = restart_ff || (count_b_ff < CW'(npc_pkg::MAX_LEN));
            end
         end
         S_BF_WR0: begin
            a_we = !use_b;
            b_we = use_b;
         end
         S_BF_WR1: begin
            a_we = !use_b;
            b_we = use_b;
            a_waddr = addr_v;
            b_waddr = addr_v;
            a_wdata = wd1_ff;
            b_wdata = wd1_ff;
         end
         S_PW_RD: begin
            raddr0 = idx_ff;
         end
         S_PW_WR: begin
            a_we = 1'b1;
            a_waddr = idx_ff;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (a_we) mem_a[a_waddr] <= a_wdata;
      if (b_we) mem_b[b_waddr] <= b_wdata;
      a_q0_ff <= mem_a[raddr0];
      a_q1_ff <= mem_a[raddr1];
      b_q0_ff <= mem_b[raddr0];
      b_q1_ff <= mem_b[raddr1];
      tw_q_ff <= (phase_ff == PH_INV) ? TW_INV[tw_idx] : TW_FWD[tw_idx];
   end

   // multiply and Barrett reduction over four stages
   assign qprod = x1_ff[59:29] * npc_pkg::MU_C;
   assign qmod  = q_ff * npc_pkg::MOD_C;
   assign rdiff = x2_ff - qmod[31:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         mv1_ff <= 1'b0;
         mv2_ff <= 1'b0;
         mv3_ff <= 1'b0;
         mv4_ff <= 1'b0;
      end else begin
         mv1_ff <= mstart_ff;
         mv2_ff <= mv1_ff;
         mv3_ff <= mv2_ff;
         mv4_ff <= mv3_ff;
      end
      x1_ff <= op_a_ff * op_b_ff;
      q_ff  <= qprod[61:31];
      x2_ff <= x1_ff[31:0];
      r_ff  <= rdiff;
      if (r_ff >= npc_pkg::MOD2_32) prod_ff <= DW'(r_ff - npc_pkg::MOD2_32);
      else if (r_ff >= npc_pkg::MOD1_32) prod_ff <= DW'(r_ff - npc_pkg::MOD1_32);
      else prod_ff <= DW'(r_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         phase_ff <= PH_FWD_A;
         count_a_ff <= '0;
         count_b_ff <= '0;
         result_len_ff <= '0;
         overflow_ff <= 1'b0;
         ready_ff <= 1'b0;
         restart_ff <= 1'b0;
         mstart_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         lg_ff <= '0;
         hlg_ff <= '0;
         bfly_ff <= '0;
         idx_ff <= '0;
      end else begin
         mstart_ff <= (state_ff == S_BF_OP) || (state_ff == S_PW_OP);
         if (rsp_load) rsp_valid_ff <= 1'b1;
         else if (rsp_tready) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (req_fire) begin
                  unique case (req_op)
                     npc_pkg::OP_LOAD_A, npc_pkg::OP_LOAD_B: begin
                        // first load after a compute starts anew
                        if (restart_ff) begin
                           restart_ff <= 1'b0;
                           overflow_ff <= 1'b0;
                           result_len_ff <= '0;
                           ready_ff <= 1'b0;
                           count_a_ff <= (req_op == npc_pkg::OP_LOAD_A) ? CW'(1) : '0;
                           count_b_ff <= (req_op == npc_pkg::OP_LOAD_B) ? CW'(1) : '0;
                        end else if (req_op == npc_pkg::OP_LOAD_A) begin
                           if (count_a_ff < CW'(npc_pkg::MAX_LEN))
                              count_a_ff <= count_a_ff + CW'(1);
                           else overflow_ff <= 1'b1;
                        end else begin
                           if (count_b_ff < CW'(npc_pkg::MAX_LEN))
                              count_b_ff <= count_b_ff + CW'(1);
                           else overflow_ff <= 1'b1;
                        end
                     end
                     npc_pkg::OP_COMPUTE: begin
                        restart_ff <= 1'b1;
                        res_coeff_ff <= '0;
                        lg_ff <= plen_lg;
                        bfly_ff <= '0;
                        idx_ff <= '0;
                        hlg_ff <= plen_lg - 4'd1;
                        if (restart_ff && ready_ff) begin
                           // operands unchanged since the last good compute: keep the product
                           res_status_ff <= npc_pkg::ST_OK;
                           res_len_ff <= result_len_ff;
                           state_ff <= S_OUT;
                        end else begin
                           ready_ff <= 1'b0;
                           result_len_ff <= '0;
                           if ((count_a_ff == '0) || (count_b_ff == '0)) begin
                              res_status_ff <= npc_pkg::ST_EMPTY;
                              res_len_ff <= '0;
                              state_ff <= S_OUT;
                           end else if (overflow_ff || (plen > CW'(npc_pkg::MAX_LEN))) begin
                              res_status_ff <= npc_pkg::ST_LONG;
                              res_len_ff <= plen;
                              state_ff <= S_OUT;
                           end else if (plen_lg == '0) begin
                              res_len_ff <= plen;
                              phase_ff <= PH_PROD;
                              state_ff <= S_PW_RD;
                           end else begin
                              res_len_ff <= plen;
                              phase_ff <= PH_FWD_A;
                              state_ff <= S_BF_RD;
                           end
                        end
                     end
                     npc_pkg::OP_READ: begin
                        res_coeff_ff <= '0;
                        res_len_ff <= result_len_ff;
                        if (!ready_ff) begin
                           res_status_ff <= npc_pkg::ST_EMPTY;
                           state_ff <= S_OUT;
                        end else if ({1'b0, req_index} >= result_len_ff) begin
                           res_status_ff <= npc_pkg::ST_RANGE;
                           state_ff <= S_OUT;
                        end else begin
                           res_status_ff <= npc_pkg::ST_OK;
                           state_ff <= S_READ;
                        end
                     end
                     default: begin
                     end
                  endcase
               end
            end
            S_READ: begin
               res_coeff_ff <= a_q0_ff;
               state_ff <= S_OUT;
            end
            S_OUT: begin
               // hold until the output register is free
               if (rsp_load) begin
                  rsp_coeff_ff <= res_coeff_ff;
                  rsp_status_ff <= res_status_ff;
                  rsp_len_ff <= res_len_ff;
                  state_ff <= S_IDLE;
               end
            end
            S_BF_RD: begin
               state_ff <= S_BF_OP;
            end
            S_BF_OP: begin
               hold_u_ff <= u_val;
               hold_sum_ff <= npc_pkg::mod_add(u_val, v_val);
               op_a_ff <= fwd ? npc_pkg::mod_sub(u_val, v_val) : v_val;
               op_b_ff <= tw_q_ff;
               state_ff <= S_BF_MUL;
            end
            S_BF_MUL: begin
               if (mv4_ff) begin
                  if (fwd) begin
                     wd0_ff <= hold_sum_ff;
                     wd1_ff <= prod_ff;
                  end else begin
                     wd0_ff <= npc_pkg::mod_add(hold_u_ff, prod_ff);
                     wd1_ff <= npc_pkg::mod_sub(hold_u_ff, prod_ff);
                  end
                  state_ff <= S_BF_WR0;
               end
            end
            S_BF_WR0: begin
               state_ff <= S_BF_WR1;
            end
            S_BF_WR1: begin
               if (!bfly_last) begin
                  bfly_ff <= bfly_ff + TWW'(1);
                  state_ff <= S_BF_RD;
               end else begin
                  bfly_ff <= '0;
                  if (fwd) begin
                     if (hlg_ff == '0) begin
                        hlg_ff <= lg_ff - 4'd1;
                        if (phase_ff == PH_FWD_A) begin
                           phase_ff <= PH_FWD_B;
                           state_ff <= S_BF_RD;
                        end else begin
                           phase_ff <= PH_PROD;
                           idx_ff <= '0;
                           state_ff <= S_PW_RD;
                        end
                     end else begin
                        hlg_ff <= hlg_ff - 4'd1;
                        state_ff <= S_BF_RD;
                     end
                  end else begin
                     if (hlg_ff == lg_ff - 4'd1) begin
                        phase_ff <= PH_SCALE;
                        idx_ff <= '0;
                        state_ff <= S_PW_RD;
                     end else begin
                        hlg_ff <= hlg_ff + 4'd1;
                        state_ff <= S_BF_RD;
                     end
                  end
               end
            end
            S_PW_RD: begin
               state_ff <= S_PW_OP;
            end
            S_PW_OP: begin
               op_a_ff <= a_q0_ff;
               op_b_ff <= (phase_ff == PH_PROD) ? b_q0_ff : SCALES[lg_ff];
               state_ff <= S_PW_MUL;
            end
            S_PW_MUL: begin
               if (mv4_ff) begin
                  wd0_ff <= prod_ff;
                  state_ff <= S_PW_WR;
               end
            end
            S_PW_WR: begin
               if (!idx_last) begin
                  idx_ff <= idx_ff + AW'(1);
                  state_ff <= S_PW_RD;
               end else begin
                  idx_ff <= '0;
                  if (phase_ff == PH_PROD) begin
                     hlg_ff <= '0;
                     bfly_ff <= '0;
                     if (lg_ff == '0) begin
                        phase_ff <= PH_SCALE;
                        state_ff <= S_PW_RD;
                     end else begin
                        phase_ff <= PH_INV;
                        state_ff <= S_BF_RD;
                     end
                  end else begin
                     // scaling done: the product is in memory a
                     ready_ff <= 1'b1;
                     result_len_ff <= res_len_ff;
                     res_status_ff <= npc_pkg::ST_OK;
                     state_ff <= S_OUT;
                  end
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_len_ff, rsp_coeff_ff};
   assign rsp_tuser  = rsp_status_ff;

endmodule

@@ tb/ntt_polynomial_convolution_checker.sv @@
`timescale 1ns / 1ps

module ntt_polynomial_convolution_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [39:0] req_tdata,
   input  logic [1:0]  req_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [47:0] rsp_tdata,
   input  logic [1:0]  rsp_tuser,
   output int          failures,
   output int          pending,
   output int          checked
);

   typedef struct {
      logic [npc_pkg::COEFF_W-1:0] coeff;
      npc_pkg::status_type         status;
      logic [10:0]                 plen;
   } answer_type;

   localparam longint unsigned PRIME = npc_pkg::MODULUS;

   logic [npc_pkg::COEFF_W-1:0] poly_a [npc_pkg::MAX_LEN];
   logic [npc_pkg::COEFF_W-1:0] poly_b [npc_pkg::MAX_LEN];
   longint unsigned    product [npc_pkg::MAX_LEN];
   int unsigned        len_a, len_b, prod_len;
   bit                 dropped, prod_valid, fresh_start;
   answer_type         answers_due [$];

   // Schoolbook product mod the prime; matches the transform result exactly
   // because the padded size always covers the full product length.
   function automatic answer_type convolve();
      answer_type r;
      int unsigned plen;
      r.coeff = '0;
      r.plen = '0;
      prod_valid = 0;
      prod_len = 0;
      if (len_a == 0 || len_b == 0) begin
         r.status = npc_pkg::ST_EMPTY;
         return r;
      end
      plen = len_a + len_b - 1;
      r.plen = plen[10:0];
      if (dropped || plen > npc_pkg::MAX_LEN) begin
         r.status = npc_pkg::ST_LONG;
         return r;
      end
      for (int k = 0; k < plen; k++) product[k] = 0;
      for (int i = 0; i < len_a; i++)
         for (int j = 0; j < len_b; j++)
            product[i+j] = (product[i+j] +
                            (longint'(poly_a[i]) * longint'(poly_b[j])) % PRIME) % PRIME;
      prod_len = plen;
      prod_valid = 1;
      r.status = npc_pkg::ST_OK;
      return r;
   endfunction

   function automatic void take_request(npc_pkg::op_type op, logic [29:0] raw,
                                        logic [9:0] idx);
      answer_type r;
      logic [npc_pkg::COEFF_W-1:0] value;
      value = npc_pkg::COEFF_W'(longint'(raw) % PRIME);
      case (op)
         npc_pkg::OP_LOAD_A, npc_pkg::OP_LOAD_B: begin
            if (fresh_start) begin
               len_a = 0; len_b = 0; dropped = 0;
               prod_len = 0; prod_valid = 0; fresh_start = 0;
            end
            if (op == npc_pkg::OP_LOAD_A) begin
               if (len_a < npc_pkg::MAX_LEN) poly_a[len_a++] = value;
               else dropped = 1;
            end else begin
               if (len_b < npc_pkg::MAX_LEN) poly_b[len_b++] = value;
               else dropped = 1;
            end
         end
         npc_pkg::OP_COMPUTE: begin
            r = convolve();
            fresh_start = 1;
            answers_due.push_back(r);
         end
         default: begin
            r.plen = prod_len[10:0];
            r.coeff = '0;
            if (!prod_valid) r.status = npc_pkg::ST_EMPTY;
            else if (idx >= prod_len) r.status = npc_pkg::ST_RANGE;
            else begin
               r.status = npc_pkg::ST_OK;
               r.coeff = npc_pkg::COEFF_W'(product[idx]);
            end
            answers_due.push_back(r);
         end
      endcase
   endfunction

   always @(posedge clock) begin
      answer_type e;
      if (reset) begin
         len_a = 0; len_b = 0; prod_len = 0;
         dropped = 0; prod_valid = 0; fresh_start = 0;
         answers_due.delete();
         failures = 0;
         checked = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (answers_due.size() == 0) begin
               $error("unexpected result transfer: %h / %0d", rsp_tdata, rsp_tuser);
               failures++;
            end else begin
               e = answers_due.pop_front();
               checked++;
               if (rsp_tdata[29:0] !== e.coeff) begin
                  $error("coeff_out: expected %0d, got %0d", e.coeff, rsp_tdata[29:0]);
                  failures++;
               end
               if (rsp_tuser !== e.status) begin
                  $error("status: expected %0d, got %0d", e.status, rsp_tuser);
                  failures++;
               end
               if (rsp_tdata[40:30] !== e.plen) begin
                  $error("product_len: expected %0d, got %0d", e.plen, rsp_tdata[40:30]);
                  failures++;
               end
            end
         end
         if (req_tvalid && req_tready)
            take_request(npc_pkg::op_type'(req_tuser), req_tdata[29:0], req_tdata[39:30]);
      end
      pending = answers_due.size();
   end

endmodule

@@ tb/ntt_polynomial_convolution_tb.sv @@
`timescale 1ns / 1ps

module ntt_polynomial_convolution_tb;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [39:0] req_tdata;    // coeff_in[29:0], read_index[39:30]
   logic [1:0]  req_tuser;    // op[1:0]
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [47:0] rsp_tdata;    // coeff_out[29:0], product_len[40:30], zero fill
   logic [1:0]  rsp_tuser;    // status[1:0]

   int failures, pending, checked;
   int send_idle_pct, recv_idle_pct;
   bit hold_results, hold_done;
   int items_sent, computes_sent, reads_sent;

   ntt_polynomial_convolution dut (.*);

   ntt_polynomial_convolution_checker checker_i (.*);

   initial begin
      clock = 0;
      forever #10 clock = ~clock;
   end

   // Hard stop: covers the largest transforms several times over.
   initial begin
      #100_000_000;
      $display("ntt_polynomial_convolution_tb: done, errors");
      $finish;
   end

   // Result side: drop ready at random, or hold off once for a long stretch on request
   // so that the output register fills and the block stalls its input.
   initial begin
      rsp_tready = 0;
      hold_done = 0;
      forever begin
         @(negedge clock);
         if (hold_results && !hold_done) begin
            hold_done = 1;
            rsp_tready = 0;
            repeat (400) @(negedge clock);
         end
         rsp_tready = ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Offer one item and wait for its transfer; valid stays high into the next item unless an idle gap is drawn.
   task automatic send(npc_pkg::op_type op, logic [29:0] coeff = '0, logic [9:0] idx = '0);
      bit taken;
      if (items_sent >= 1266) begin
         send_idle_pct = 0;
         recv_idle_pct = 0;
      end else if (items_sent >= 633) begin
         send_idle_pct = 62;
         recv_idle_pct = 29;
      end
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid = 0;
         @(negedge clock);
      end
      req_tvalid = 1;
      req_tuser  = op;
      req_tdata  = {idx, coeff};
      // ready only moves at the rising edge, so its value here holds for the next edge
      taken = 0;
      while (!taken) begin
         taken = req_tready;
         @(negedge clock);
      end
      items_sent++;
      if (op == npc_pkg::OP_COMPUTE) computes_sent++;
      if (op == npc_pkg::OP_READ) reads_sent++;
   endtask

   function automatic logic [29:0] any_coeff();
      case ($urandom_range(5))
         0: return 30'h3FFF_FFFF;
         1: return 30'(npc_pkg::MODULUS - 1 + $urandom_range(2));
         2: return '0;
         default: return 30'($urandom());
      endcase
   endfunction

   // Load both operands, compute, then read a mix of valid and out-of-range indexes.
   task automatic run_product(int na, int nb, int nreads);
      int plen;
      plen = (na > 0 && nb > 0) ? na + nb - 1 : 0;
      for (int k = 0; k < na || k < nb; k++) begin
         if (k < na) send(npc_pkg::OP_LOAD_A, any_coeff());
         if (k < nb) send(npc_pkg::OP_LOAD_B, any_coeff());
      end
      if ($urandom_range(9) == 0) send(npc_pkg::OP_READ, '0, 10'($urandom()));
      send(npc_pkg::OP_COMPUTE, 30'($urandom()), 10'($urandom()));
      if ($urandom_range(15) == 0) send(npc_pkg::OP_COMPUTE);
      repeat (nreads) begin
         if ($urandom_range(7) == 0 || plen == 0)
            send(npc_pkg::OP_READ, 30'($urandom()), 10'($urandom()));
         else send(npc_pkg::OP_READ, 30'($urandom()), 10'($urandom_range(plen + 1)));
      end
   endtask

   task automatic random_sequence(int seq);
      int na, nb;
      // rare big cases: full-size transform, dropped load with a too-long product
      if (seq == 2) begin
         run_product(300, 215, 0);
         send(npc_pkg::OP_READ, '0, 10'd513);
         send(npc_pkg::OP_READ, '0, 10'd512);
         send(npc_pkg::OP_READ, '0, 10'd514);
         send(npc_pkg::OP_READ, '0, '0);
         return;
      end
      if (seq == 4) begin
         run_product(npc_pkg::MAX_LEN + 1, 1, 2);
         return;
      end
      if ($urandom_range(19) == 0) begin
         // noise: random op with random payload
         send(npc_pkg::op_type'($urandom_range(3)), 30'($urandom()), 10'($urandom()));
         return;
      end
      na = ($urandom_range(9) == 0) ? $urandom_range(64) : $urandom_range(1, 12);
      nb = ($urandom_range(9) == 0) ? $urandom_range(64) : $urandom_range(1, 12);
      if ($urandom_range(24) == 0) na = 0;
      run_product(na, nb, $urandom_range(2, 20));
   endtask

   initial begin
      int seq;
      reset = 1;
      req_tvalid = 0;
      req_tdata = '0;
      req_tuser = npc_pkg::OP_LOAD_A;
      hold_results = 0;
      send_idle_pct = 29;
      recv_idle_pct = 62;
      items_sent = 0;
      computes_sent = 0;
      reads_sent = 0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // directed: read before any result, compute with empty operands
      send(npc_pkg::OP_READ, '0, '0);
      send(npc_pkg::OP_COMPUTE);
      send(npc_pkg::OP_READ, '0, 10'h3FF);
      // extreme coefficients, including values at and above the prime
      send(npc_pkg::OP_LOAD_A, 30'h3FFF_FFFF);
      send(npc_pkg::OP_LOAD_A, 30'(npc_pkg::MODULUS));
      send(npc_pkg::OP_LOAD_A, 30'(npc_pkg::MODULUS - 1));
      send(npc_pkg::OP_LOAD_B, 30'(npc_pkg::MODULUS - 1));
      send(npc_pkg::OP_LOAD_B, '0);
      send(npc_pkg::OP_READ, '0, '0);
      send(npc_pkg::OP_COMPUTE, 30'h3FFF_FFFF, 10'h3FF);
      send(npc_pkg::OP_READ, '0, 10'd0);
      send(npc_pkg::OP_READ, '0, 10'd3);
      send(npc_pkg::OP_READ, '0, 10'd4);
      send(npc_pkg::OP_READ, 30'h3FFF_FFFF, 10'h3FF);
      send(npc_pkg::OP_COMPUTE);
      send(npc_pkg::OP_READ, '0, 10'd1);
      // a load after compute starts anew: the old product is gone
      send(npc_pkg::OP_LOAD_B, 30'h1555_5555);
      send(npc_pkg::OP_READ, '0, 10'd0);
      send(npc_pkg::OP_COMPUTE);
      send(npc_pkg::OP_LOAD_A, 30'h2AAA_AAAA);
      send(npc_pkg::OP_COMPUTE);
      send(npc_pkg::OP_READ, '0, 10'd0);
      send(npc_pkg::OP_READ, '0, 10'd1);

      seq = 0;
      while (items_sent < 1900) begin
         if (seq == 1) hold_results = 1;
         random_sequence(seq);
         seq++;
      end
      req_tvalid = 0;

      wait (pending == 0);
      repeat (50) @(posedge clock);
      $display("Sent %0d items (%0d computes, %0d reads) in %0d operand sets;",
               items_sent, computes_sent, reads_sent, seq);
      $display("checked %0d results, including dropped loads, long products and a full-size transform.",
               checked);
      if (failures == 0 && pending == 0)
         $display("ntt_polynomial_convolution_tb: done, clean");
      else
         $display("ntt_polynomial_convolution_tb: done, errors");
      $finish;
   end

endmodule
